// ===== sv/triangle_scanline_fill_shaded_defines.svh =====
// Assertion macros of the triangle fill checker.
`ifndef TRIANGLE_SCANLINE_FILL_SHADED_DEFINES_SVH
`define TRIANGLE_SCANLINE_FILL_SHADED_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tsf_pkg.sv =====
// Shared constants, types and helpers of the triangle scanline fill block.
`default_nettype none
package tsf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int W_W        = $clog2(MAX_WIDTH + 1);
    localparam int H_W        = $clog2(MAX_HEIGHT + 1);
    localparam int FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int FB_AW      = $clog2(FB_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // divider operand widths
    localparam int DIV_NW = 45;
    localparam int DIV_DW = 34;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_SHADE  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [2:0][7:0]    c;   // c[0] red, c[1] green, c[2] blue
    } vtx_t;

    typedef struct packed {
        logic signed [31:0] lx;
        logic signed [31:0] rx;
        logic [2:0][25:0]   lc;
        logic [2:0][25:0]   rc;
    } span_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_NW-1:0] num;
        logic [DIV_DW-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DIV_NW-1:0] quot;
    } div_rsp_t;

    // saturate an 8.16 colour to a byte
    function automatic logic [7:0] to_byte(input logic signed [33:0] c);
        logic [7:0] r;
        if (c < 0)
            r = 8'd0;
        else if (|c[33:24])
            r = 8'd255;
        else
            r = c[23:16];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/tsf_if.sv =====
// Request and response channel interfaces of the triangle fill block.
`default_nettype none
interface tsf_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [1:0]         vertex_slot;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         pixel_col;
    logic [7:0]         pixel_row;

    modport source (output valid, req_type, vertex_slot, coord_x, coord_y,
                    red, green, blue, pixel_col, pixel_row, input ready);
    modport sink   (input valid, req_type, vertex_slot, coord_x, coord_y,
                    red, green, blue, pixel_col, pixel_row, output ready);
endinterface

interface tsf_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_red;
    logic [7:0]  read_green;
    logic [7:0]  read_blue;
    logic [31:0] triangles_drawn;

    modport source (output valid, read_red, read_green, read_blue, triangles_drawn,
                    input ready);
    modport sink   (input valid, read_red, read_green, read_blue, triangles_drawn,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/tsf_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
`default_nettype none
module tsf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tsf_pkg::div_req_t req,
    output tsf_pkg::div_rsp_t rsp
);
    import tsf_pkg::*;

    localparam int QW  = DIV_NW - 1;
    localparam int CNW = $clog2(QW + 1);

    logic [DIV_DW-1:0]   rem_reg;
    logic [QW-1:0]       quo_reg;
    logic [DIV_DW-1:0]   den_reg;
    logic                neg_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [CNW-1:0]      cnt_reg;

    logic signed [DIV_NW-1:0] mag;
    logic [DIV_DW:0]          trial;
    logic                     ge;

    assign mag   = req.num[DIV_NW-1] ? -req.num : req.num;
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= mag[QW-1:0];
                den_reg  <= req.den;
                neg_reg  <= req.num[DIV_NW-1];
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
                quo_reg <= {quo_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
endmodule
`default_nettype wire

// ===== sv/triangle_scanline_fill_shaded.sv =====
// Top level: scanline triangle fill with flat or Gouraud shading into a framebuffer.
//
//  channel | dir | handshake      | word
//  --------+-----+----------------+-----------------------------------------------
//  req     | in  | valid/ready    | request kind, slot, 12.4 x/y, rgb, read col/row
//  rsp     | out | valid/ready    | read rgb, triangles drawn
//  cfg     | in  | cfg_we         | register index, data (width, height, shade)
//
//  After reset a clearing pass writes every framebuffer pixel, one per cycle,
//  before req.ready rises. A pixel read makes one framebuffer read.
//  A draw runs per edge four divisions (slope and three colour steps), skips
//  rows outside the screen and does a span table read-modify-write per row
//  inside, then per filled row three divisions, a start colour setup and one
//  pixel per cycle.
//  The response register holds a finished word while the next request runs;
//  a stalled rsp only delays the end of the following request.
`default_nettype none
module triangle_scanline_fill_shaded (
    input  logic                              clk,
    input  logic                              rst_n,
    tsf_req_if.sink                           req,
    tsf_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [tsf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tsf_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_FIN,
        S_E_SETUP, S_E_DIV, S_E_RD, S_E_WR,
        S_F_ROW, S_F_LOAD, S_F_DIV, S_F_MUL, S_F_PIX
    } state_t;

    state_t state_reg;

    // configuration
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic       shade_reg;

    // vertex slots and counter
    vtx_t        vtx_reg [3];
    logic [31:0] count_reg;

    // response word
    logic        rsp_valid_reg;
    logic [23:0] rsp_pix_reg;
    logic [31:0] rsp_count_reg;
    logic [23:0] pix_reg;
    logic        rd_ok_reg;

    // edge walk
    logic [1:0]         edge_reg;
    logic [1:0]         k_reg;
    vtx_t               ea_reg;
    vtx_t               eb_reg;
    logic [13:0]        n_reg;
    logic [13:0]        i_reg;
    logic signed [17:0] row_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] slope_reg;
    logic signed [28:0] col_reg   [3];
    logic signed [28:0] cstep_reg [3];
    logic [MAX_HEIGHT-1:0] valid_reg;

    // span fill
    logic [23:0]        flat_reg;
    logic [H_W-1:0]     y_reg;
    span_t              span_reg;
    logic signed [25:0] step_reg [3];
    logic signed [33:0] acc_reg  [3];
    logic signed [34:0] d_reg;
    logic signed [17:0] xp_reg;
    logic signed [17:0] xb_reg;

    logic [FB_AW-1:0] clr_reg;

    // divider
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic                     div_go_reg;
    logic signed [DIV_NW-1:0] div_num_reg;
    logic [DIV_DW-1:0]        div_den_reg;

    // memories
    logic [23:0]      fb_mem [FB_DEPTH];
    logic             fb_we;
    logic [FB_AW-1:0] fb_waddr;
    logic [23:0]      fb_wdata;
    logic [FB_AW-1:0] fb_raddr;
    logic [23:0]      fb_rdata;

    span_t            span_mem [MAX_HEIGHT];
    logic             sp_we;
    logic [ROW_W-1:0] sp_waddr;
    span_t            sp_wdata;
    logic [ROW_W-1:0] sp_raddr;
    span_t            sp_rdata;

    assign div_req.start = div_go_reg;
    assign div_req.num   = div_num_reg;
    assign div_req.den   = div_den_reg;

    tsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // clip limits, saturated to the framebuffer size
    logic [W_W-1:0] wlim;
    logic [H_W-1:0] hlim;
    assign wlim = (32'(width_reg)  > MAX_WIDTH)  ? W_W'(MAX_WIDTH)  : W_W'(width_reg);
    assign hlim = (32'(height_reg) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT) : H_W'(height_reg);

    // edge setup: take the top vertex first
    vtx_t               vp, vq, va, vb;
    logic signed [16:0] dy;
    logic signed [16:0] dx;
    logic [17:0]        dy_round;
    assign vp       = vtx_reg[edge_reg];
    assign vq       = vtx_reg[(edge_reg == 2'd2) ? 2'd0 : edge_reg + 2'd1];
    assign va       = (vq.y < vp.y) ? vq : vp;
    assign vb       = (vq.y < vp.y) ? vp : vq;
    assign dy       = 17'(vb.y) - 17'(va.y);
    assign dx       = 17'(vb.x) - 17'(va.x);
    assign dy_round = 18'(dy) + 18'd15;

    // colour difference of the next channel to divide along an edge
    logic [1:0]        kc;
    logic signed [8:0] dc;
    assign kc = (state_reg == S_E_SETUP) ? 2'd0 : k_reg;
    assign dc = $signed({1'b0, eb_reg.c[kc]}) - $signed({1'b0, ea_reg.c[kc]});

    // span-table update for the current edge step
    span_t              sp_new;
    logic               row_valid;
    logic signed [31:0] xs;
    logic               row_in;
    assign row_valid = valid_reg[row_reg[ROW_W-1:0]];
    assign xs        = x_reg[31:0];
    assign row_in    = (row_reg >= 0) && (row_reg < $signed(18'(hlim)));

    always_comb
    begin
        sp_new = sp_rdata;
        if (!row_valid || xs < sp_rdata.lx)
        begin
            sp_new.lx = xs;
            for (int k = 0; k < 3; k++)
                sp_new.lc[k] = col_reg[k][25:0];
        end
        if (!row_valid || xs > sp_rdata.rx)
        begin
            sp_new.rx = xs;
            for (int k = 0; k < 3; k++)
                sp_new.rc[k] = col_reg[k][25:0];
        end
    end

    // span setup terms
    logic signed [33:0] span_len;
    logic [1:0]         kf;
    logic signed [26:0] sdc;
    span_t              sp_src;
    assign sp_src   = (state_reg == S_F_LOAD) ? sp_rdata : span_reg;
    assign span_len = 34'(sp_src.rx) - 34'(sp_src.lx) + 34'sd65536;
    assign kf       = (state_reg == S_F_LOAD) ? 2'd0 : k_reg + 2'd1;
    assign sdc      = 27'($signed(sp_src.rc[kf])) - 27'($signed(sp_src.lc[kf]));

    // pixel range of the span, floor of both ends, clipped to the window
    logic signed [17:0] xa_c, xb_c, xe_c, wmax;
    logic signed [34:0] d0;
    assign wmax = $signed(18'(wlim)) - 18'sd1;
    assign xe_c = {{2{span_reg.rx[31]}}, span_reg.rx[31:16]};
    assign xa_c = (span_reg.lx[31] == 1'b1) ? 18'sd0 : 18'(span_reg.lx[31:16]);
    assign xb_c = (xe_c > wmax) ? wmax : xe_c;
    assign d0   = $signed({1'b0, xa_c, 16'b0}) - 35'(span_reg.lx);

    // initial pixel offset and its colour term, one channel per cycle
    logic [17:0]        off0;
    logic signed [44:0] prod;
    assign off0 = d_reg[34] ? 18'd0 : d_reg[33:16];
    assign prod = step_reg[k_reg] * $signed({1'b0, off0});

    logic [23:0] pix_out;
    assign pix_out = shade_reg ? {to_byte(acc_reg[0]), to_byte(acc_reg[1]),
                                  to_byte(acc_reg[2])} : flat_reg;

    // memory port control
    always_comb
    begin
        fb_we    = 1'b0;
        fb_waddr = clr_reg;
        fb_wdata = '0;
        if (state_reg == S_F_PIX)
        begin
            fb_we    = 1'b1;
            fb_waddr = FB_AW'(y_reg[ROW_W-1:0]) * FB_AW'(MAX_WIDTH)
                     + FB_AW'(xp_reg[COL_W-1:0]);
            fb_wdata = pix_out;
        end
        else if (state_reg == S_CLEAR)
            fb_we = 1'b1;
    end

    assign fb_raddr = FB_AW'(req.pixel_row) * FB_AW'(MAX_WIDTH) + FB_AW'(req.pixel_col);
    assign sp_we    = (state_reg == S_E_WR);
    assign sp_waddr = row_reg[ROW_W-1:0];
    assign sp_wdata = sp_new;
    assign sp_raddr = (state_reg == S_F_ROW) ? y_reg[ROW_W-1:0] : row_reg[ROW_W-1:0];

    always_ff @(posedge clk)
    begin
        if (fb_we)
            fb_mem[fb_waddr] <= fb_wdata;
        fb_rdata <= fb_mem[fb_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sp_we)
            span_mem[sp_waddr] <= sp_wdata;
        sp_rdata <= span_mem[sp_raddr];
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.read_red        = rsp_pix_reg[23:16];
    assign rsp.read_green      = rsp_pix_reg[15:8];
    assign rsp.read_blue       = rsp_pix_reg[7:0];
    assign rsp.triangles_drawn = rsp_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            shade_reg     <= 1'b1;
            for (int s = 0; s < 3; s++)
                vtx_reg[s] <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            div_go_reg    <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            div_go_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_SHADE:  shade_reg  <= cfg_data[0];
                    default:    ;
                endcase
            end

            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == FB_AW'(FB_DEPTH - 1))
                        state_reg <= S_IDLE;
                end

                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        pix_reg <= '0;
                        unique case (req.req_type)
                            REQ_LOAD:
                            begin
                                if (req.vertex_slot != 2'd3)
                                begin
                                    vtx_reg[req.vertex_slot].x <= req.coord_x;
                                    vtx_reg[req.vertex_slot].y <= req.coord_y;
                                    vtx_reg[req.vertex_slot].c <=
                                        {req.blue, req.green, req.red};
                                end
                                state_reg <= S_FIN;
                            end
                            REQ_DRAW:
                            begin
                                flat_reg  <= {req.red, req.green, req.blue};
                                valid_reg <= '0;
                                edge_reg  <= 2'd0;
                                state_reg <= S_E_SETUP;
                            end
                            REQ_READ:
                            begin
                                rd_ok_reg <= (32'(req.pixel_col) < MAX_WIDTH)
                                          && (32'(req.pixel_row) < MAX_HEIGHT);
                                state_reg <= S_READ;
                            end
                            default:
                            begin
                                count_reg <= '0;
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end

                S_READ:
                begin
                    pix_reg   <= rd_ok_reg ? fb_rdata : 24'd0;
                    state_reg <= S_FIN;
                end

                S_FIN:
                begin
                    // hold until the response register is free
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_pix_reg   <= pix_reg;
                        rsp_count_reg <= count_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                S_E_SETUP:
                begin
                    ea_reg <= va;
                    eb_reg <= vb;
                    n_reg  <= dy_round[17:4];
                    if (dy <= 0)
                    begin
                        // flat edge adds no rows
                        if (edge_reg == 2'd2)
                        begin
                            y_reg     <= '0;
                            state_reg <= S_F_ROW;
                        end
                        else
                            edge_reg <= edge_reg + 2'd1;
                    end
                    else
                    begin
                        div_num_reg <= {{12{dx[16]}}, dx, 16'b0};
                        div_den_reg <= DIV_DW'(dy[15:0]) | (DIV_DW'(dy[16]) << 16);
                        div_go_reg  <= 1'b1;
                        k_reg       <= 2'd0;
                        state_reg   <= S_E_DIV;
                    end
                end

                S_E_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (k_reg == 2'd0)
                            slope_reg <= div_rsp.quot[33:0];
                        else
                            cstep_reg[k_reg - 2'd1] <= div_rsp.quot[28:0];
                        if (k_reg == 2'd3)
                        begin
                            i_reg   <= '0;
                            row_reg <= {{6{ea_reg.y[15]}}, ea_reg.y[15:4]};
                            x_reg   <= {{6{ea_reg.x[15]}}, ea_reg.x, 12'b0};
                            for (int k = 0; k < 3; k++)
                                col_reg[k] <= {5'b0, ea_reg.c[k], 16'b0};
                            state_reg <= S_E_RD;
                        end
                        else
                        begin
                            k_reg       <= k_reg + 2'd1;
                            div_go_reg  <= 1'b1;
                            div_num_reg <= {{16{dc[8]}}, dc, 20'b0};
                        end
                    end
                end

                S_E_RD:
                begin
                    if (i_reg == n_reg)
                    begin
                        if (edge_reg == 2'd2)
                        begin
                            y_reg     <= '0;
                            state_reg <= S_F_ROW;
                        end
                        else
                        begin
                            edge_reg  <= edge_reg + 2'd1;
                            state_reg <= S_E_SETUP;
                        end
                    end
                    else if (row_in)
                        state_reg <= S_E_WR;
                    else
                    begin
                        // drop rows off screen, advance the edge
                        i_reg   <= i_reg + 14'd1;
                        row_reg <= row_reg + 18'sd1;
                        x_reg   <= x_reg + slope_reg;
                        for (int k = 0; k < 3; k++)
                            col_reg[k] <= col_reg[k] + cstep_reg[k];
                    end
                end

                S_E_WR:
                begin
                    valid_reg[row_reg[ROW_W-1:0]] <= 1'b1;
                    i_reg   <= i_reg + 14'd1;
                    row_reg <= row_reg + 18'sd1;
                    x_reg   <= x_reg + slope_reg;
                    for (int k = 0; k < 3; k++)
                        col_reg[k] <= col_reg[k] + cstep_reg[k];
                    state_reg <= S_E_RD;
                end

                S_F_ROW:
                begin
                    if (y_reg == hlim)
                    begin
                        count_reg <= count_reg + 32'd1;
                        state_reg <= S_FIN;
                    end
                    else if (valid_reg[y_reg[ROW_W-1:0]])
                        state_reg <= S_F_LOAD;
                    else
                        y_reg <= y_reg + 1'b1;
                end

                S_F_LOAD:
                begin
                    span_reg    <= sp_rdata;
                    div_num_reg <= {{2{sdc[26]}}, sdc, 16'b0};
                    div_den_reg <= span_len;
                    div_go_reg  <= 1'b1;
                    k_reg       <= 2'd0;
                    state_reg   <= S_F_DIV;
                end

                S_F_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        step_reg[k_reg] <= div_rsp.quot[25:0];
                        if (k_reg == 2'd2)
                        begin
                            if (xa_c > xb_c)
                            begin
                                y_reg     <= y_reg + 1'b1;
                                state_reg <= S_F_ROW;
                            end
                            else
                            begin
                                xp_reg    <= xa_c;
                                xb_reg    <= xb_c;
                                d_reg     <= d0;
                                k_reg     <= 2'd0;
                                state_reg <= S_F_MUL;
                            end
                        end
                        else
                        begin
                            k_reg       <= k_reg + 2'd1;
                            div_num_reg <= {{2{sdc[26]}}, sdc, 16'b0};
                            div_go_reg  <= 1'b1;
                        end
                    end
                end

                S_F_MUL:
                begin
                    acc_reg[k_reg] <= 34'($signed(span_reg.lc[k_reg])) + prod[33:0];
                    if (k_reg == 2'd2)
                        state_reg <= S_F_PIX;
                    else
                        k_reg <= k_reg + 2'd1;
                end

                S_F_PIX:
                begin
                    // step the colour once the offset has started to grow
                    if (!d_reg[34])
                    begin
                        for (int k = 0; k < 3; k++)
                            acc_reg[k] <= acc_reg[k] + 34'(step_reg[k]);
                    end
                    d_reg <= d_reg + 35'sd65536;
                    if (xp_reg == xb_reg)
                    begin
                        y_reg     <= y_reg + 1'b1;
                        state_reg <= S_F_ROW;
                    end
                    else
                        xp_reg <= xp_reg + 18'sd1;
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/tsf_checker.sv =====
// Port-level checker of the triangle fill block and its bind.
`default_nettype none
`include "triangle_scanline_fill_shaded_defines.svh"
module tsf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  out_red,
    input wire logic [7:0]  out_green,
    input wire logic [7:0]  out_blue,
    input wire logic [31:0] out_count
);
    logic [31:0] last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= '0;
        else if (out_valid && out_ready)
            last_reg <= out_count;
    end

    `TSF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)
        && $stable(out_count), "stalled response word changed")
    `TSF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready,
        !in_ready, "request taken while previous one still in work")
    `TSF_ASSERT_IMP(a_count_step, clk, rst_n, out_valid && out_ready,
        out_count == last_reg || out_count == last_reg + 32'd1 || out_count == 32'd0,
        "triangle count jumped between responses")
endmodule

bind triangle_scanline_fill_shaded tsf_checker u_tsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_red   (rsp.read_red),
    .out_green (rsp.read_green),
    .out_blue  (rsp.read_blue),
    .out_count (rsp.triangles_drawn)
);
`default_nettype wire
